// File: design/ddpid_pkg.sv
// shared widths, register indexes, status type and saturation helpers for the dual pid core
package ddpid_pkg;

    localparam int DATA_W    = 32;
    localparam int GAIN_W    = 24;
    localparam int IDX_W     = 4;
    localparam int TOT_W     = 40;
    localparam int FRAC_BITS = 16;
    localparam int YAW_SCALE = 20;

    localparam int YAW_W    = DATA_W + $clog2(YAW_SCALE) + 1;
    localparam int DIFF_W   = DATA_W + 1;
    localparam int MC_W     = TOT_W;
    localparam int PROD_W   = MC_W + GAIN_W;
    localparam int ACC_W    = PROD_W - FRAC_BITS + 2;
    localparam int SAT_IN_W = PROD_W + 2;
    localparam int TURN_W   = DATA_W + GAIN_W;
    localparam int BASE_W   = DATA_W + FRAC_BITS + 1;
    localparam int NUM_W    = ((BASE_W > TURN_W) ? BASE_W : TURN_W) + 1;
    localparam int DVS_W    = GAIN_W + 1;
    localparam int QUO_W    = DATA_W - 1;
    localparam int REM_W    = DVS_W + QUO_W;

    localparam logic signed [DATA_W-1:0] S_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] S_MIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic signed [TOT_W-1:0]  T_MAX = {1'b0, {(TOT_W-1){1'b1}}};
    localparam logic signed [TOT_W-1:0]  T_MIN = {1'b1, {(TOT_W-1){1'b0}}};

    // configuration register indexes
    localparam logic [IDX_W-1:0] REG_LIN_KP = IDX_W'(0);
    localparam logic [IDX_W-1:0] REG_LIN_KI = IDX_W'(1);
    localparam logic [IDX_W-1:0] REG_LIN_KD = IDX_W'(2);
    localparam logic [IDX_W-1:0] REG_ANG_KP = IDX_W'(3);
    localparam logic [IDX_W-1:0] REG_ANG_KI = IDX_W'(4);
    localparam logic [IDX_W-1:0] REG_ANG_KD = IDX_W'(5);
    localparam logic [IDX_W-1:0] REG_SEP    = IDX_W'(6);
    localparam logic [IDX_W-1:0] REG_RADIUS = IDX_W'(7);

    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_stat;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SAT_IN_W-1:0] v);
        if (v[SAT_IN_W-1:DATA_W-1] == '0 || v[SAT_IN_W-1:DATA_W-1] == '1) begin
            return v[DATA_W-1:0];
        end else if (v[SAT_IN_W-1]) begin
            return S_MIN;
        end else begin
            return S_MAX;
        end
    endfunction

    function automatic logic signed [TOT_W-1:0] sat_tot(input logic signed [SAT_IN_W-1:0] v);
        if (v[SAT_IN_W-1:TOT_W-1] == '0 || v[SAT_IN_W-1:TOT_W-1] == '1) begin
            return v[TOT_W-1:0];
        end else if (v[SAT_IN_W-1]) begin
            return T_MIN;
        end else begin
            return T_MAX;
        end
    endfunction

endpackage

// File: design/diff_drive_dual_pid_core.sv
// differential-drive velocity controller: two pid loops and inverse kinematics, serial datapath
//
//   channel  direction  handshake                 payload
//   in       sink       i_in_valid / o_in_ready   five wheel, yaw and target fields
//   out      source     o_out_valid / i_out_ready left and right setpoints
//   cfg      sink       i_cfg_valid / o_cfg_ready register index and 24-bit data
//
// from an accepted beat to a valid result the core makes eight passes through the
// bit-serial multiplier and two divisions, each division cut short when the quotient
// saturates or the numerator is zero; the multiplier works through the 24-bit gain and the
// divider through 31 quotient bits. one item is in flight at a time; a new beat is
// taken while the previous result waits on the output. reset restores the register defaults
// and clears the loop errors and error sums; cfg writes are taken every cycle.
module diff_drive_dual_pid_core import ddpid_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic signed [DATA_W-1:0] i_left_wheel_vel,
    input  logic signed [DATA_W-1:0] i_right_wheel_vel,
    input  logic signed [DATA_W-1:0] i_raw_yaw_rate,
    input  logic signed [DATA_W-1:0] i_target_lin_vel,
    input  logic signed [DATA_W-1:0] i_target_ang_vel,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic signed [DATA_W-1:0] o_left_setpoint,
    output logic signed [DATA_W-1:0] o_right_setpoint,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [IDX_W-1:0]         i_cfg_index,
    input  logic [GAIN_W-1:0]        i_cfg_data
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PREP  = 3'd1;
    localparam logic [2:0] ST_ISSUE = 3'd2;
    localparam logic [2:0] ST_MUL   = 3'd3;
    localparam logic [2:0] ST_DSET  = 3'd4;
    localparam logic [2:0] ST_DWAIT = 3'd5;
    localparam logic [2:0] ST_DONE  = 3'd6;

    localparam int OP_W = 3;
    localparam logic [OP_W-1:0] OP_XVEL  = 3'd0;
    localparam logic [OP_W-1:0] OP_LIN_P = 3'd1;
    localparam logic [OP_W-1:0] OP_LIN_I = 3'd2;
    localparam logic [OP_W-1:0] OP_LIN_D = 3'd3;
    localparam logic [OP_W-1:0] OP_ANG_P = 3'd4;
    localparam logic [OP_W-1:0] OP_ANG_I = 3'd5;
    localparam logic [OP_W-1:0] OP_ANG_D = 3'd6;
    localparam logic [OP_W-1:0] OP_TURN  = 3'd7;

    // control
    logic [2:0]               r_state, n_state;
    logic [OP_W-1:0]          r_op, n_op;
    logic                     r_side, n_side;
    logic                     r_out_valid, n_out_valid;

    // configuration
    logic [GAIN_W-1:0]        r_lin_kp, n_lin_kp;
    logic [GAIN_W-1:0]        r_lin_ki, n_lin_ki;
    logic [GAIN_W-1:0]        r_lin_kd, n_lin_kd;
    logic [GAIN_W-1:0]        r_ang_kp, n_ang_kp;
    logic [GAIN_W-1:0]        r_ang_ki, n_ang_ki;
    logic [GAIN_W-1:0]        r_ang_kd, n_ang_kd;
    logic [GAIN_W-1:0]        r_sep, n_sep;
    logic [GAIN_W-1:0]        r_radius, n_radius;

    // loop state
    logic signed [DATA_W-1:0] r_last_lin, n_last_lin;
    logic signed [DATA_W-1:0] r_last_ang, n_last_ang;
    logic signed [TOT_W-1:0]  r_lin_tot, n_lin_tot;
    logic signed [TOT_W-1:0]  r_ang_tot, n_ang_tot;

    // payload
    logic signed [DATA_W-1:0] r_wl, n_wl;
    logic signed [DATA_W-1:0] r_wr, n_wr;
    logic signed [DATA_W-1:0] r_yaw, n_yaw;
    logic signed [DATA_W-1:0] r_tlin, n_tlin;
    logic signed [DATA_W-1:0] r_tang, n_tang;
    logic signed [DIFF_W-1:0] r_wsum, n_wsum;
    logic signed [DATA_W-1:0] r_elin, n_elin;
    logic signed [DATA_W-1:0] r_eang, n_eang;
    logic signed [DIFF_W-1:0] r_diff, n_diff;
    logic signed [ACC_W-1:0]  r_acc, n_acc;
    logic signed [DATA_W-1:0] r_clin, n_clin;
    logic signed [TURN_W-1:0] r_turn, n_turn;
    logic signed [DATA_W-1:0] r_left_q, n_left_q;
    logic signed [DATA_W-1:0] r_right_q, n_right_q;
    logic signed [DATA_W-1:0] r_left_sp, n_left_sp;
    logic signed [DATA_W-1:0] r_right_sp, n_right_sp;

    // datapath
    logic                       w_mul_start;
    logic                       w_div_start;
    t_unit_stat                 w_mul_stat;
    t_unit_stat                 w_div_stat;
    logic signed [MC_W-1:0]     w_mcand;
    logic [GAIN_W-1:0]          w_mplier;
    logic signed [PROD_W-1:0]   w_prod;
    logic signed [DATA_W-1:0]   w_quo;
    logic signed [YAW_W-1:0]    w_theta_full;
    logic signed [DATA_W-1:0]   w_theta;
    logic signed [DATA_W-1:0]   w_xvel;
    logic signed [ACC_W-1:0]    w_term;
    logic signed [DATA_W-1:0]   w_acc_sat;
    logic signed [NUM_W-1:0]    w_base;
    logic signed [NUM_W-1:0]    w_num;

    assign w_theta_full = YAW_W'(r_yaw) * YAW_W'(YAW_SCALE);
    assign w_theta      = sat32(SAT_IN_W'(w_theta_full));
    assign w_xvel       = sat32(SAT_IN_W'(w_prod >>> (FRAC_BITS + 1)));
    assign w_term       = ACC_W'(w_prod >>> FRAC_BITS);
    assign w_acc_sat    = sat32(SAT_IN_W'(r_acc));
    assign w_base       = NUM_W'(r_clin) <<< (FRAC_BITS + 1);
    assign w_num        = r_side ? (w_base + NUM_W'(r_turn)) : (w_base - NUM_W'(r_turn));

    assign w_mul_start = (r_state == ST_ISSUE);
    assign w_div_start = (r_state == ST_DSET);

    always_comb begin
        case (r_op)
            OP_XVEL:  w_mcand = MC_W'(r_wsum);
            OP_LIN_P: w_mcand = MC_W'(r_elin);
            OP_LIN_I: w_mcand = MC_W'(r_lin_tot);
            OP_LIN_D: w_mcand = MC_W'(r_diff);
            OP_ANG_P: w_mcand = MC_W'(r_eang);
            OP_ANG_I: w_mcand = MC_W'(r_ang_tot);
            OP_ANG_D: w_mcand = MC_W'(r_diff);
            OP_TURN:  w_mcand = MC_W'(w_acc_sat);
            default:  w_mcand = '0;
        endcase
        case (r_op)
            OP_XVEL:  w_mplier = r_radius;
            OP_LIN_P: w_mplier = r_lin_kp;
            OP_LIN_I: w_mplier = r_lin_ki;
            OP_LIN_D: w_mplier = r_lin_kd;
            OP_ANG_P: w_mplier = r_ang_kp;
            OP_ANG_I: w_mplier = r_ang_ki;
            OP_ANG_D: w_mplier = r_ang_kd;
            OP_TURN:  w_mplier = r_sep;
            default:  w_mplier = '0;
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_side      = r_side;
        n_out_valid = r_out_valid;
        n_lin_kp    = r_lin_kp;
        n_lin_ki    = r_lin_ki;
        n_lin_kd    = r_lin_kd;
        n_ang_kp    = r_ang_kp;
        n_ang_ki    = r_ang_ki;
        n_ang_kd    = r_ang_kd;
        n_sep       = r_sep;
        n_radius    = r_radius;
        n_last_lin  = r_last_lin;
        n_last_ang  = r_last_ang;
        n_lin_tot   = r_lin_tot;
        n_ang_tot   = r_ang_tot;
        n_wl        = r_wl;
        n_wr        = r_wr;
        n_yaw       = r_yaw;
        n_tlin      = r_tlin;
        n_tang      = r_tang;
        n_wsum      = r_wsum;
        n_elin      = r_elin;
        n_eang      = r_eang;
        n_diff      = r_diff;
        n_acc       = r_acc;
        n_clin      = r_clin;
        n_turn      = r_turn;
        n_left_q    = r_left_q;
        n_right_q   = r_right_q;
        n_left_sp   = r_left_sp;
        n_right_sp  = r_right_sp;

        if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_LIN_KP: n_lin_kp = i_cfg_data;
                REG_LIN_KI: n_lin_ki = i_cfg_data;
                REG_LIN_KD: n_lin_kd = i_cfg_data;
                REG_ANG_KP: n_ang_kp = i_cfg_data;
                REG_ANG_KI: n_ang_ki = i_cfg_data;
                REG_ANG_KD: n_ang_kd = i_cfg_data;
                REG_SEP:    n_sep    = i_cfg_data;
                REG_RADIUS: n_radius = i_cfg_data;
                default: ;
            endcase
        end

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_wl    = i_left_wheel_vel;
                    n_wr    = i_right_wheel_vel;
                    n_yaw   = i_raw_yaw_rate;
                    n_tlin  = i_target_lin_vel;
                    n_tang  = i_target_ang_vel;
                    n_state = ST_PREP;
                end
            end
            ST_PREP: begin
                n_wsum  = DIFF_W'(r_wl) + DIFF_W'(r_wr);
                n_eang  = sat32(SAT_IN_W'(r_tang) - SAT_IN_W'(w_theta));
                n_op    = OP_XVEL;
                n_state = ST_ISSUE;
            end
            ST_ISSUE: begin
                // loop state moves as the proportional product of each loop starts
                case (r_op)
                    OP_LIN_P: begin
                        n_lin_tot  = sat_tot(SAT_IN_W'(r_lin_tot) + SAT_IN_W'(r_elin));
                        n_diff     = DIFF_W'(r_elin) - DIFF_W'(r_last_lin);
                        n_last_lin = r_elin;
                    end
                    OP_ANG_P: begin
                        n_clin     = w_acc_sat;
                        n_ang_tot  = sat_tot(SAT_IN_W'(r_ang_tot) + SAT_IN_W'(r_eang));
                        n_diff     = DIFF_W'(r_eang) - DIFF_W'(r_last_ang);
                        n_last_ang = r_eang;
                    end
                    default: ;
                endcase
                n_state = ST_MUL;
            end
            ST_MUL: begin
                if (w_mul_stat.done) begin
                    case (r_op)
                        OP_XVEL:  n_elin = sat32(SAT_IN_W'(r_tlin) - SAT_IN_W'(w_xvel));
                        OP_LIN_P: n_acc  = w_term;
                        OP_ANG_P: n_acc  = w_term;
                        OP_TURN:  n_turn = TURN_W'(w_prod);
                        default:  n_acc  = r_acc + w_term;
                    endcase
                    if (r_op == OP_TURN) begin
                        n_side  = 1'b0;
                        n_state = ST_DSET;
                    end else begin
                        n_op    = r_op + OP_W'(1);
                        n_state = ST_ISSUE;
                    end
                end
            end
            ST_DSET: begin
                n_state = ST_DWAIT;
            end
            ST_DWAIT: begin
                if (w_div_stat.done) begin
                    if (!r_side) begin
                        n_left_q = w_quo;
                        n_side   = 1'b1;
                        n_state  = ST_DSET;
                    end else begin
                        n_right_q = w_quo;
                        n_state   = ST_DONE;
                    end
                end
            end
            ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_left_sp   = r_left_q;
                    n_right_sp  = r_right_q;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_op        <= OP_XVEL;
            r_side      <= 1'b0;
            r_out_valid <= 1'b0;
            r_lin_kp    <= GAIN_W'(65536);
            r_lin_ki    <= GAIN_W'(6554);
            r_lin_kd    <= GAIN_W'(13107);
            r_ang_kp    <= GAIN_W'(65536);
            r_ang_ki    <= GAIN_W'(6554);
            r_ang_kd    <= GAIN_W'(13107);
            r_sep       <= GAIN_W'(45875);
            r_radius    <= GAIN_W'(26870);
            r_last_lin  <= '0;
            r_last_ang  <= '0;
            r_lin_tot   <= '0;
            r_ang_tot   <= '0;
        end else begin
            r_state     <= n_state;
            r_op        <= n_op;
            r_side      <= n_side;
            r_out_valid <= n_out_valid;
            r_lin_kp    <= n_lin_kp;
            r_lin_ki    <= n_lin_ki;
            r_lin_kd    <= n_lin_kd;
            r_ang_kp    <= n_ang_kp;
            r_ang_ki    <= n_ang_ki;
            r_ang_kd    <= n_ang_kd;
            r_sep       <= n_sep;
            r_radius    <= n_radius;
            r_last_lin  <= n_last_lin;
            r_last_ang  <= n_last_ang;
            r_lin_tot   <= n_lin_tot;
            r_ang_tot   <= n_ang_tot;
        end
    end

    always_ff @(posedge i_clk) begin
        r_wl       <= n_wl;
        r_wr       <= n_wr;
        r_yaw      <= n_yaw;
        r_tlin     <= n_tlin;
        r_tang     <= n_tang;
        r_wsum     <= n_wsum;
        r_elin     <= n_elin;
        r_eang     <= n_eang;
        r_diff     <= n_diff;
        r_acc      <= n_acc;
        r_clin     <= n_clin;
        r_turn     <= n_turn;
        r_left_q   <= n_left_q;
        r_right_q  <= n_right_q;
        r_left_sp  <= n_left_sp;
        r_right_sp <= n_right_sp;
    end

    ddpid_mul u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_mul_start),
        .i_mcand  (w_mcand),
        .i_mplier (w_mplier),
        .o_stat   (w_mul_stat),
        .o_prod   (w_prod)
    );

    ddpid_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_div_start),
        .i_num    (w_num),
        .i_radius (r_radius),
        .o_stat   (w_div_stat),
        .o_quo    (w_quo)
    );

    assign o_in_ready       = (r_state == ST_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_left_setpoint  = r_left_sp;
    assign o_right_setpoint = r_right_sp;
    assign o_cfg_ready      = 1'b1;

`ifndef SYNTHESIS
    a_mul_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mul_start |-> !w_mul_stat.busy)
        else $error("multiplier started while busy");

    a_div_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_start |-> !w_div_stat.busy)
        else $error("divider started while busy");

    a_ready_units_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> (!w_mul_stat.busy && !w_div_stat.busy))
        else $error("input ready while a serial unit is still working");

    a_accept_to_prep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == ST_PREP))
        else $error("accepted beat did not start the sequence");
`endif

endmodule

// File: design/ddpid_mul.sv
// bit-serial shift-add multiplier: signed operand times unsigned gain, one gain bit per cycle
module ddpid_mul import ddpid_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic signed [MC_W-1:0]   i_mcand,
    input  logic [GAIN_W-1:0]        i_mplier,
    output t_unit_stat               o_stat,
    output logic signed [PROD_W-1:0] o_prod
);

    localparam int CNT_W = $clog2(GAIN_W);

    logic                     r_busy, n_busy;
    logic                     r_done, n_done;
    logic [CNT_W-1:0]         r_cnt, n_cnt;
    logic signed [PROD_W-1:0] r_mc, n_mc;
    logic [GAIN_W-1:0]        r_mp, n_mp;
    logic signed [PROD_W-1:0] r_prod, n_prod;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_mc   = r_mc;
        n_mp   = r_mp;
        n_prod = r_prod;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_mc   = PROD_W'(i_mcand);
            n_mp   = i_mplier;
            n_prod = '0;
        end else if (r_busy) begin
            if (r_mp[0]) begin
                n_prod = r_prod + r_mc;
            end
            n_mc  = r_mc <<< 1;
            n_mp  = r_mp >> 1;
            n_cnt = r_cnt + CNT_W'(1);
            if (r_cnt == CNT_W'(GAIN_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt  <= n_cnt;
        r_mc   <= n_mc;
        r_mp   <= n_mp;
        r_prod <= n_prod;
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_prod      = r_prod;

endmodule

// File: design/ddpid_div.sv
// restoring divider for the wheel setpoints: one quotient bit per cycle, saturating to 32 bits
module ddpid_div import ddpid_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic signed [NUM_W-1:0]  i_num,
    input  logic [GAIN_W-1:0]        i_radius,
    output t_unit_stat               o_stat,
    output logic signed [DATA_W-1:0] o_quo
);

    localparam int CNT_W = $clog2(QUO_W);

    localparam logic [1:0] DV_IDLE  = 2'd0;
    localparam logic [1:0] DV_CHECK = 2'd1;
    localparam logic [1:0] DV_ITER  = 2'd2;
    localparam logic [1:0] DV_FIN   = 2'd3;

    logic [1:0]               r_phase, n_phase;
    logic                     r_done, n_done;
    logic                     r_neg, n_neg;
    logic                     r_ovf, n_ovf;
    logic [NUM_W-1:0]         r_mag, n_mag;
    logic [DVS_W-1:0]         r_d, n_d;
    logic [REM_W-1:0]         r_rem, n_rem;
    logic [REM_W-1:0]         r_dvs, n_dvs;
    logic [QUO_W-1:0]         r_q, n_q;
    logic [CNT_W-1:0]         r_cnt, n_cnt;
    logic signed [DATA_W-1:0] r_quo, n_quo;

    logic [REM_W-1:0]         w_lim;
    logic                     w_ge;

    // divisor scaled to the first quotient bit past the 32-bit range
    assign w_lim = {r_d, {QUO_W{1'b0}}};
    assign w_ge  = (r_rem >= r_dvs);

    always_comb begin
        n_phase = r_phase;
        n_done  = 1'b0;
        n_neg   = r_neg;
        n_ovf   = r_ovf;
        n_mag   = r_mag;
        n_d     = r_d;
        n_rem   = r_rem;
        n_dvs   = r_dvs;
        n_q     = r_q;
        n_cnt   = r_cnt;
        n_quo   = r_quo;
        case (r_phase)
            DV_IDLE: begin
                if (i_start) begin
                    n_neg   = i_num[NUM_W-1];
                    n_mag   = i_num[NUM_W-1] ? NUM_W'(-i_num) : NUM_W'(i_num);
                    n_d     = {i_radius, 1'b0};
                    n_phase = DV_CHECK;
                end
            end
            DV_CHECK: begin
                n_q   = '0;
                n_cnt = '0;
                if (r_mag == '0) begin
                    n_ovf   = 1'b0;
                    n_phase = DV_FIN;
                end else if (r_mag >= NUM_W'(w_lim)) begin
                    // also covers a zero radius with a nonzero numerator
                    n_ovf   = 1'b1;
                    n_phase = DV_FIN;
                end else begin
                    n_ovf   = 1'b0;
                    n_rem   = r_mag[REM_W-1:0];
                    n_dvs   = w_lim >> 1;
                    n_phase = DV_ITER;
                end
            end
            DV_ITER: begin
                if (w_ge) begin
                    n_rem = r_rem - r_dvs;
                end
                n_q   = {r_q[QUO_W-2:0], w_ge};
                n_dvs = r_dvs >> 1;
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(QUO_W - 1)) begin
                    n_phase = DV_FIN;
                end
            end
            DV_FIN: begin
                if (r_ovf) begin
                    n_quo = r_neg ? S_MIN : S_MAX;
                end else if (r_neg) begin
                    n_quo = -{1'b0, r_q};
                end else begin
                    n_quo = {1'b0, r_q};
                end
                n_done  = 1'b1;
                n_phase = DV_IDLE;
            end
            default: begin
                n_phase = DV_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= DV_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_neg <= n_neg;
        r_ovf <= n_ovf;
        r_mag <= n_mag;
        r_d   <= n_d;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
        r_q   <= n_q;
        r_cnt <= n_cnt;
        r_quo <= n_quo;
    end

    assign o_stat.busy = (r_phase != DV_IDLE);
    assign o_stat.done = r_done;
    assign o_quo       = r_quo;

endmodule
